### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle consequence, active during reset as well
`define ASSERT_NEXT(label, clk, trig, cons, msg) \
   label: assert property (@(posedge clk) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/core/suf_pkg.sv
// ----------------------------------------------------------------------------
// suf_pkg
// Types and constants for the smoothed upwind face coefficient block.
// ----------------------------------------------------------------------------
package suf_pkg;

   localparam int DATA_W = 32;

   // result regime codes
   typedef enum logic [1:0] {
      REGIME_NEAR     = 2'd0,
      REGIME_FAR      = 2'd1,
      REGIME_BLEND    = 2'd2,
      REGIME_BOUNDARY = 2'd3
   } suf_regime_type;

   // one face request
   typedef struct packed {
      logic                     one_sided;
      logic signed [DATA_W-1:0] pot_near;
      logic signed [DATA_W-1:0] pot_far;
      logic signed [DATA_W-1:0] pot_face;
      logic signed [DATA_W-1:0] overlap_near;
      logic signed [DATA_W-1:0] overlap_far;
      logic signed [DATA_W-1:0] coef_near;
      logic signed [DATA_W-1:0] coef_far;
   } suf_req_type;

   // one face result
   typedef struct packed {
      logic signed [DATA_W-1:0] face_value;
      logic                     write_face;
      suf_regime_type           regime;
   } suf_rsp_type;

   // data riding alongside the width divider
   typedef struct packed {
      logic                     bnd;
      logic                     bnd_wr;
      logic                     zero_w;
      logic signed [DATA_W:0]   diff;
      logic [DATA_W-1:0]        mag;
      logic                     neg;
      logic [DATA_W-1:0]        coef_near;
      logic [DATA_W-1:0]        coef_far;
   } suf_side1_type;

   // data riding alongside the blend divider
   typedef struct packed {
      logic                     write;
      suf_regime_type           regime;
      logic [DATA_W-1:0]        base;
      logic                     neg;
   } suf_side2_type;

endpackage

### rtl/core/suf_div.sv
// ----------------------------------------------------------------------------
// suf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module suf_div #(
   parameter int NUM_W = 62,
   parameter int DEN_W = 32,
   parameter int Q_W   = 31,
   parameter int SB_W  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_side,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic [SB_W-1:0]  out_side
);

   logic             valid_ff [0:Q_W];
   logic [DEN_W-1:0] rem_ff   [0:Q_W];
   logic [DEN_W-1:0] den_ff   [0:Q_W];
   logic [Q_W-1:0]   low_ff   [0:Q_W];
   logic [Q_W-1:0]   quo_ff   [0:Q_W];
   logic [SB_W-1:0]  side_ff  [0:Q_W];
   logic [NUM_W-1:0] top_in;

   // quotient fits Q_W bits, so the upper part is below the divisor
   assign top_in = in_num >> Q_W;

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= top_in[DEN_W-1:0];
      den_ff[0]  <= in_den;
      low_ff[0]  <= in_num[Q_W-1:0];
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= Q_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   sub;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      assign trial  = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
      assign sub    = trial - {1'b0, den_ff[k-1]};
      assign ge     = trial >= {1'b0, den_ff[k-1]};
      assign rem_in = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_ff[k-1];
         low_ff[k]  <= {low_ff[k-1][Q_W-2:0], 1'b0};
         quo_ff[k]  <= {quo_ff[k-1][Q_W-2:0], ge};
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quo   = quo_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

### rtl/core/smoothed_upwind_face_coefficient_top.sv
// Requests pass stage 1, width divider, stages 3 and 4, blend divider and output.
// Throughput: one face per cycle; busy stays low, requests are never refused.
// Depth is set by the two bit-serial divider pipelines (31 and 32 stages).
// Synchronous active-high reset clears every stage valid bit; no result
// strobes in the cycle after reset. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
// smoothed_upwind_face_coefficient_top
// Face coefficient from potential upwinding with a smoothed transition.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smoothed_upwind_face_coefficient_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  suf_pkg::suf_req_type req_data,
   output logic                rsp_strobe,
   output suf_pkg::suf_rsp_type rsp_data
);
   import suf_pkg::*;

   localparam int OV_W = DATA_W - 1;
   localparam int P1_W = 2 * OV_W;
   localparam int P2_W = 2 * DATA_W;

   // ---------------- stage 1: decode, clamp, product ----------------
   logic [OV_W-1:0]   a_in, b_in;
   logic [DATA_W:0]   cdiff_in;
   suf_side1_type     side1_in;

   assign a_in = (req_data.overlap_near > 0) ? req_data.overlap_near[OV_W-1:0] : '0;
   assign b_in = (req_data.overlap_far > 0) ? req_data.overlap_far[OV_W-1:0] : '0;
   assign cdiff_in = (req_data.coef_far >= req_data.coef_near)
      ? ({req_data.coef_far[DATA_W-1], req_data.coef_far}
         - {req_data.coef_near[DATA_W-1], req_data.coef_near})
      : ({req_data.coef_near[DATA_W-1], req_data.coef_near}
         - {req_data.coef_far[DATA_W-1], req_data.coef_far});

   always_comb begin
      side1_in.bnd       = req_data.one_sided;
      side1_in.bnd_wr    = req_data.pot_near >= req_data.pot_face;
      side1_in.zero_w    = (a_in == '0) || (b_in == '0);
      side1_in.diff      = {req_data.pot_far[DATA_W-1], req_data.pot_far}
                           - {req_data.pot_near[DATA_W-1], req_data.pot_near};
      side1_in.mag       = cdiff_in[DATA_W-1:0];
      side1_in.neg       = req_data.coef_far < req_data.coef_near;
      side1_in.coef_near = req_data.coef_near;
      side1_in.coef_far  = req_data.coef_far;
   end

   logic              s1_valid_ff;
   logic [P1_W-1:0]   s1_prod_ff;
   logic [DATA_W-1:0] s1_sum_ff;
   suf_side1_type     s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= a_in * b_in;
      s1_sum_ff  <= {1'b0, a_in} + {1'b0, b_in};
      s1_side_ff <= side1_in;
   end

   // ---------------- width divider: a*b / (a+b) ----------------
   logic                  d1_valid;
   logic [OV_W-1:0]       d1_quo;
   logic [$bits(suf_side1_type)-1:0] d1_side_vec;
   suf_side1_type         d1_side;

   suf_div #(
      .NUM_W(P1_W), .DEN_W(DATA_W), .Q_W(OV_W), .SB_W($bits(suf_side1_type))
   ) u_width_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_num   (s1_prod_ff),
      .in_den   (s1_sum_ff),
      .in_side  (s1_side_ff),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_side (d1_side_vec)
   );

   assign d1_side = suf_side1_type'(d1_side_vec);

   // ---------------- stage 3: upwind decision and blend position ----------------
   logic [DATA_W-1:0] wq_in, w_in, t_in;
   logic [DATA_W+1:0] tw_in;
   logic              near_in, far_in;
   suf_side2_type     side2_in;

   assign wq_in  = d1_side.zero_w ? '0 : {1'b0, d1_quo};
   assign w_in   = (wq_in == '0) ? DATA_W'(1) : wq_in;
   assign tw_in  = $signed({2'b00, w_in}) + $signed({d1_side.diff[DATA_W], d1_side.diff});
   assign near_in = ($signed({d1_side.diff[DATA_W], d1_side.diff})
                     + $signed({2'b00, w_in})) < 0;
   assign far_in  = $signed({d1_side.diff[DATA_W], d1_side.diff}) > $signed({2'b00, w_in});
   assign t_in   = (w_in < DATA_W'(2)) ? w_in : tw_in[DATA_W-1:0];

   always_comb begin
      side2_in.neg = d1_side.neg;
      if (d1_side.bnd) begin
         side2_in.write  = d1_side.bnd_wr;
         side2_in.regime = REGIME_BOUNDARY;
         side2_in.base   = d1_side.bnd_wr ? d1_side.coef_near : '0;
      end else if (near_in) begin
         side2_in.write  = 1'b1;
         side2_in.regime = REGIME_NEAR;
         side2_in.base   = d1_side.coef_near;
      end else if (far_in) begin
         side2_in.write  = 1'b1;
         side2_in.regime = REGIME_FAR;
         side2_in.base   = d1_side.coef_far;
      end else begin
         side2_in.write  = 1'b1;
         side2_in.regime = REGIME_BLEND;
         side2_in.base   = d1_side.coef_near;
      end
   end

   logic              s3_valid_ff;
   logic [DATA_W-1:0] s3_w_ff, s3_t_ff, s3_mag_ff;
   suf_side2_type     s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_w_ff    <= w_in;
      s3_t_ff    <= t_in;
      s3_mag_ff  <= d1_side.mag;
      s3_side_ff <= side2_in;
   end

   // ---------------- stage 4: blend product ----------------
   logic              s4_valid_ff;
   logic [P2_W-1:0]   s4_prod_ff;
   logic [DATA_W-1:0] s4_w_ff;
   suf_side2_type     s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_prod_ff <= s3_mag_ff * s3_t_ff;
      s4_w_ff    <= s3_w_ff;
      s4_side_ff <= s3_side_ff;
   end

   // ---------------- blend divider: (mag*t + w) / 2w ----------------
   logic [P2_W:0]     num2_in;
   logic [DATA_W-1:0] den2_in;
   logic              d2_valid;
   logic [DATA_W-1:0] d2_quo;
   logic [$bits(suf_side2_type)-1:0] d2_side_vec;
   suf_side2_type     d2_side;

   assign num2_in = {1'b0, s4_prod_ff} + {{(P2_W+1-DATA_W){1'b0}}, s4_w_ff};
   assign den2_in = {s4_w_ff[DATA_W-2:0], 1'b0};

   suf_div #(
      .NUM_W(P2_W + 1), .DEN_W(DATA_W), .Q_W(DATA_W), .SB_W($bits(suf_side2_type))
   ) u_blend_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s4_valid_ff),
      .in_num   (num2_in),
      .in_den   (den2_in),
      .in_side  (s4_side_ff),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_side (d2_side_vec)
   );

   assign d2_side = suf_side2_type'(d2_side_vec);

   // ---------------- output register ----------------
   logic [DATA_W-1:0] val_in;
   logic              out_valid_ff;
   suf_rsp_type       out_ff;

   assign val_in = (d2_side.regime == REGIME_BLEND)
      ? (d2_side.neg ? d2_side.base - d2_quo : d2_side.base + d2_quo)
      : d2_side.base;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff.face_value <= val_in;
      out_ff.write_face <= d2_side.write;
      out_ff.regime     <= d2_side.regime;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

   // ---------------- checks ----------------
   `ASSERT_IMPLY(a_nowrite_bnd, clock, reset, rsp_strobe && !rsp_data.write_face, rsp_data.regime == REGIME_BOUNDARY, "no-write result outside boundary regime")
   `ASSERT_IMPLY(a_nowrite_zero, clock, reset, rsp_strobe && !rsp_data.write_face, rsp_data.face_value == '0, "no-write result carries nonzero value")
   `ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe, "result strobe right after reset")

endmodule
